### src/fbpa_pkg.sv
package fbpa_pkg;

   localparam int MAX_ELEMENTS_DEF = 256;
   localparam int GUARD_BYTES_DEF  = 8;

   localparam int ADDR_W      = 32;
   // rounded payload (up to 65536) plus guards (up to 64) fits in 17 bits
   localparam int STRIDE_W    = 17;
   localparam int CSR_INDEX_W = 3;
   localparam int UPC_W       = 5;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;
   localparam logic [1:0] CMD_RSVD  = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [1:0] ST_BAD_ADDR  = 2'd2;
   localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ADDRESS     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARTITION_OFFSET = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ELEMENT_SIZE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ELEMENT_COUNT    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARTITION_NUMBER = 3'd4;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] element_address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] result_address;
      logic [15:0] owner_partition;
   } rsp_type;

   typedef enum logic [3:0] {
      UOP_NOP,
      UOP_CLEAR,
      UOP_LATCH,
      UOP_BASE,
      UOP_OFFSET,
      UOP_DIV_GO,
      UOP_PUSH,
      UOP_OWNER,
      UOP_POP,
      UOP_GROW,
      UOP_MUL,
      UOP_ADDR,
      UOP_RESP
   } uop_type;

   typedef enum logic [3:0] {
      UC_NEXT,
      UC_ALWAYS,
      UC_NO_START,
      UC_CMD_ALLOC,
      UC_CMD_RSVD,
      UC_STRIDE_ZERO,
      UC_DIV_BUSY,
      UC_ADDR_BAD,
      UC_NOT_ALLOC,
      UC_IS_QUERY,
      UC_HEAD_NULL,
      UC_CANNOT_GROW,
      UC_CLR_MORE
   } ucond_type;

   typedef logic [UPC_W-1:0] upc_type;

   localparam upc_type U_CLEAR     = 5'd0;
   localparam upc_type U_IDLE      = 5'd1;
   localparam upc_type U_DISPATCH  = 5'd2;
   localparam upc_type U_CHK_CMD   = 5'd3;
   localparam upc_type U_OFFSET    = 5'd4;
   localparam upc_type U_DIV_GO    = 5'd5;
   localparam upc_type U_DIV_WAIT  = 5'd6;
   localparam upc_type U_CHK_ADDR  = 5'd7;
   localparam upc_type U_CHK_ALLOC = 5'd8;
   localparam upc_type U_CHK_QUERY = 5'd9;
   localparam upc_type U_PUSH      = 5'd10;
   localparam upc_type U_QUERY     = 5'd11;
   localparam upc_type U_ALLOC     = 5'd12;
   localparam upc_type U_POP       = 5'd13;
   localparam upc_type U_GROW_CHK  = 5'd14;
   localparam upc_type U_GROW      = 5'd15;
   localparam upc_type U_MUL       = 5'd16;
   localparam upc_type U_ADDR      = 5'd17;
   localparam upc_type U_R_OK      = 5'd18;
   localparam upc_type U_R_EXH     = 5'd19;
   localparam upc_type U_R_BAD     = 5'd20;
   localparam upc_type U_R_NALLOC  = 5'd21;

   typedef struct packed {
      uop_type    op;
      ucond_type  cond;
      upc_type    target;
      logic [1:0] status;
   } uword_type;

   typedef struct packed {
      uop_type    op;
      logic [1:0] status;
   } ctrl_type;

   typedef struct packed {
      logic cmd_alloc;
      logic cmd_rsvd;
      logic is_query;
      logic stride_zero;
      logic div_busy;
      logic addr_bad;
      logic not_alloc;
      logic head_null;
      logic cannot_grow;
      logic clr_more;
   } flags_type;

   function automatic uword_type uw(input uop_type op, input ucond_type cond,
                                    input upc_type target, input logic [1:0] status);
      uword_type w;
      w.op     = op;
      w.cond   = cond;
      w.target = target;
      w.status = status;
      return w;
   endfunction

   // control store: op runs in the step, then jump to target when cond holds, else go on to the next step
   function automatic uword_type ucode_rom(input upc_type upc);
      uword_type w;
      unique case (upc)
         U_CLEAR:     w = uw(UOP_CLEAR,  UC_CLR_MORE,    U_CLEAR,     ST_OK);
         U_IDLE:      w = uw(UOP_LATCH,  UC_NO_START,    U_IDLE,      ST_OK);
         U_DISPATCH:  w = uw(UOP_BASE,   UC_CMD_ALLOC,   U_ALLOC,     ST_OK);
         U_CHK_CMD:   w = uw(UOP_NOP,    UC_CMD_RSVD,    U_R_BAD,     ST_OK);
         U_OFFSET:    w = uw(UOP_OFFSET, UC_STRIDE_ZERO, U_R_BAD,     ST_OK);
         U_DIV_GO:    w = uw(UOP_DIV_GO, UC_NEXT,        U_DIV_WAIT,  ST_OK);
         U_DIV_WAIT:  w = uw(UOP_NOP,    UC_DIV_BUSY,    U_DIV_WAIT,  ST_OK);
         U_CHK_ADDR:  w = uw(UOP_NOP,    UC_ADDR_BAD,    U_R_BAD,     ST_OK);
         U_CHK_ALLOC: w = uw(UOP_NOP,    UC_NOT_ALLOC,   U_R_NALLOC,  ST_OK);
         U_CHK_QUERY: w = uw(UOP_NOP,    UC_IS_QUERY,    U_QUERY,     ST_OK);
         U_PUSH:      w = uw(UOP_PUSH,   UC_ALWAYS,      U_R_OK,      ST_OK);
         U_QUERY:     w = uw(UOP_OWNER,  UC_ALWAYS,      U_R_OK,      ST_OK);
         U_ALLOC:     w = uw(UOP_NOP,    UC_HEAD_NULL,   U_GROW_CHK,  ST_OK);
         U_POP:       w = uw(UOP_POP,    UC_ALWAYS,      U_MUL,       ST_OK);
         U_GROW_CHK:  w = uw(UOP_NOP,    UC_CANNOT_GROW, U_R_EXH,     ST_OK);
         U_GROW:      w = uw(UOP_GROW,   UC_NEXT,        U_MUL,       ST_OK);
         U_MUL:       w = uw(UOP_MUL,    UC_NEXT,        U_ADDR,      ST_OK);
         U_ADDR:      w = uw(UOP_ADDR,   UC_ALWAYS,      U_R_OK,      ST_OK);
         U_R_OK:      w = uw(UOP_RESP,   UC_ALWAYS,      U_IDLE,      ST_OK);
         U_R_EXH:     w = uw(UOP_RESP,   UC_ALWAYS,      U_IDLE,      ST_EXHAUSTED);
         U_R_BAD:     w = uw(UOP_RESP,   UC_ALWAYS,      U_IDLE,      ST_BAD_ADDR);
         U_R_NALLOC:  w = uw(UOP_RESP,   UC_ALWAYS,      U_IDLE,      ST_NOT_ALLOC);
         default:     w = uw(UOP_NOP,    UC_ALWAYS,      U_IDLE,      ST_OK);
      endcase
      return w;
   endfunction

endpackage

### src/fbpa_divider.sv
module fbpa_divider import fbpa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  logic [ADDR_W-1:0]   dividend,
   input  logic [STRIDE_W-1:0] divisor,
   output logic                busy,
   output logic [ADDR_W-1:0]   quotient,
   output logic [STRIDE_W-1:0] remainder
);

   localparam int CntW = $clog2(ADDR_W + 1);

   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic [ADDR_W-1:0]   quo_ff, quo_in;
   logic [STRIDE_W-1:0] rem_ff, rem_in;
   logic [STRIDE_W-1:0] div_ff, div_in;
   logic [STRIDE_W:0]   trial;
   logic [STRIDE_W:0]   diff;
   logic                fits;

   // restoring division, one quotient bit a cycle
   always_comb begin
      trial  = {rem_ff, quo_ff[ADDR_W-1]};
      diff   = trial - {1'b0, div_ff};
      fits   = trial >= {1'b0, div_ff};
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      if (go) begin
         cnt_in = CntW'(ADDR_W);
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CntW'(1);
         quo_in = {quo_ff[ADDR_W-2:0], fits};
         rem_in = fits ? diff[STRIDE_W-1:0] : trial[STRIDE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy      = cnt_ff != '0;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");

endmodule

### src/fbpa_datapath.sv
module fbpa_datapath import fbpa_pkg::*; #(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
   parameter int GUARD_BYTES  = GUARD_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_type               ctrl,
   input  req_type                req_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata,
   output flags_type              flags,
   output logic                   rsp_valid,
   output rsp_type                rsp_data
);

   localparam int IdxW      = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CntW      = $clog2(MAX_ELEMENTS + 1);
   localparam int HeadGuard = GUARD_BYTES / 2;
   localparam int ProdW     = IdxW + STRIDE_W;

   typedef struct packed {
      logic        alloc;
      logic [15:0] stamp;
   } slot_type;

   typedef struct packed {
      logic            valid;
      logic [IdxW-1:0] idx;
   } link_type;

   // configuration
   logic [31:0] base_ff, base_in;
   logic [31:0] poff_ff, poff_in;
   logic [15:0] esize_ff, esize_in;
   logic [8:0]  ecount_ff, ecount_in;
   logic [15:0] pnum_ff, pnum_in;

   // control state
   link_type        head_ff, head_in;
   logic [CntW-1:0] hwm_ff, hwm_in;
   logic [IdxW-1:0] clr_ff, clr_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [1:0]          cmd_ff, cmd_in;
   logic [31:0]         addr_ff, addr_in;
   logic [31:0]         pbase_ff, pbase_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;
   logic [31:0]         off_ff, off_in;
   logic [IdxW-1:0]     idx_ff, idx_in;
   logic [31:0]         prod_ff, prod_in;
   logic [31:0]         res_addr_ff, res_addr_in;
   logic [15:0]         owner_ff, owner_in;
   rsp_type             rsp_ff, rsp_in;

   // stores
   slot_type slot_mem [MAX_ELEMENTS];
   link_type link_mem [MAX_ELEMENTS];
   slot_type slot_rd_ff;
   link_type link_rd_ff;

   logic            slot_we;
   logic [IdxW-1:0] slot_waddr;
   slot_type        slot_wdata;
   logic            link_we;
   link_type        link_wdata;

   logic                div_go;
   logic                div_busy;
   logic [31:0]         quotient;
   logic [STRIDE_W-1:0] remainder;
   logic [IdxW-1:0]     q_idx;

   logic [STRIDE_W-1:0] rounded;
   logic [STRIDE_W-1:0] stride_calc;
   logic [CntW-1:0]     limit;
   logic [ProdW-1:0]    prod_full;

   fbpa_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .go        (div_go),
      .dividend  (off_ff),
      .divisor   (stride_ff),
      .busy      (div_busy),
      .quotient  (quotient),
      .remainder (remainder)
   );

   assign q_idx = quotient[IdxW-1:0];

   always_comb begin
      rounded     = (STRIDE_W'(esize_ff) + STRIDE_W'(3)) & ~STRIDE_W'(3);
      stride_calc = rounded + STRIDE_W'(GUARD_BYTES);
      if (32'(ecount_ff) > 32'(MAX_ELEMENTS)) begin
         limit = CntW'(MAX_ELEMENTS);
      end else begin
         limit = CntW'(ecount_ff);
      end
      prod_full = ProdW'(idx_ff) * ProdW'(stride_ff);
   end

   always_comb begin
      flags.cmd_alloc   = cmd_ff == CMD_ALLOC;
      flags.cmd_rsvd    = cmd_ff == CMD_RSVD;
      flags.is_query    = cmd_ff == CMD_QUERY;
      flags.stride_zero = stride_ff == '0;
      flags.div_busy    = div_busy;
      flags.addr_bad    = (quotient >= 32'(limit)) || (remainder != '0);
      flags.not_alloc   = !slot_rd_ff.alloc;
      flags.head_null   = !head_ff.valid;
      flags.cannot_grow = !(hwm_ff < limit);
      flags.clr_more    = clr_ff != IdxW'(MAX_ELEMENTS - 1);
   end

   // configuration writes
   always_comb begin
      base_in   = base_ff;
      poff_in   = poff_ff;
      esize_in  = esize_ff;
      ecount_in = ecount_ff;
      pnum_in   = pnum_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BASE_ADDRESS:     base_in   = csr_wdata;
            CSR_PARTITION_OFFSET: poff_in   = csr_wdata;
            CSR_ELEMENT_SIZE:     esize_in  = csr_wdata[15:0];
            CSR_ELEMENT_COUNT:    ecount_in = csr_wdata[8:0];
            CSR_PARTITION_NUMBER: pnum_in   = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // micro-op decode
   always_comb begin
      head_in      = head_ff;
      hwm_in       = hwm_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      pbase_in     = pbase_ff;
      stride_in    = stride_ff;
      off_in       = off_ff;
      idx_in       = idx_ff;
      prod_in      = prod_ff;
      res_addr_in  = res_addr_ff;
      owner_in     = owner_ff;
      rsp_in       = rsp_ff;
      slot_we      = 1'b0;
      slot_waddr   = q_idx;
      slot_wdata   = '0;
      link_we      = 1'b0;
      link_wdata   = head_ff;
      div_go       = 1'b0;
      unique case (ctrl.op)
         UOP_NOP: ;
         UOP_CLEAR: begin
            slot_we    = 1'b1;
            slot_waddr = clr_ff;
            clr_in     = clr_ff + IdxW'(1);
         end
         UOP_LATCH: begin
            cmd_in      = req_data.command;
            addr_in     = req_data.element_address;
            res_addr_in = '0;
            owner_in    = '0;
         end
         UOP_BASE: begin
            pbase_in  = base_ff + poff_ff;
            stride_in = stride_calc;
         end
         UOP_OFFSET: begin
            off_in = addr_ff - 32'(HeadGuard) - pbase_ff;
         end
         UOP_DIV_GO: begin
            div_go = 1'b1;
         end
         UOP_PUSH: begin
            slot_we       = 1'b1;
            slot_wdata    = '0;
            link_we       = 1'b1;
            link_wdata    = head_ff;
            head_in.valid = 1'b1;
            head_in.idx   = q_idx;
         end
         UOP_OWNER: begin
            owner_in = slot_rd_ff.stamp;
         end
         UOP_POP: begin
            idx_in           = head_ff.idx;
            head_in          = link_rd_ff;
            slot_we          = 1'b1;
            slot_waddr       = head_ff.idx;
            slot_wdata.alloc = 1'b1;
            slot_wdata.stamp = pnum_ff;
         end
         UOP_GROW: begin
            // never-used slot comes straight off the high-water mark
            idx_in           = hwm_ff[IdxW-1:0];
            hwm_in           = hwm_ff + CntW'(1);
            slot_we          = 1'b1;
            slot_waddr       = hwm_ff[IdxW-1:0];
            slot_wdata.alloc = 1'b1;
            slot_wdata.stamp = pnum_ff;
         end
         UOP_MUL: begin
            prod_in = 32'(prod_full);
         end
         UOP_ADDR: begin
            res_addr_in = pbase_ff + prod_ff + 32'(HeadGuard);
         end
         UOP_RESP: begin
            rsp_valid_in           = 1'b1;
            rsp_in.status          = ctrl.status;
            rsp_in.result_address  = res_addr_ff;
            rsp_in.owner_partition = owner_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= '0;
         poff_ff       <= '0;
         esize_ff      <= '0;
         ecount_ff     <= '0;
         pnum_ff       <= '0;
         head_ff.valid <= 1'b0;
         head_ff.idx   <= '0;
         hwm_ff        <= '0;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         base_ff      <= base_in;
         poff_ff      <= poff_in;
         esize_ff     <= esize_in;
         ecount_ff    <= ecount_in;
         pnum_ff      <= pnum_in;
         head_ff      <= head_in;
         hwm_ff       <= hwm_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      addr_ff     <= addr_in;
      pbase_ff    <= pbase_in;
      stride_ff   <= stride_in;
      off_ff      <= off_in;
      idx_ff      <= idx_in;
      prod_ff     <= prod_in;
      res_addr_ff <= res_addr_in;
      owner_ff    <= owner_in;
      rsp_ff      <= rsp_in;
   end

   // slot store: allocated flag and partition stamp
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_rd_ff <= slot_mem[q_idx];
   end

   // free-list links, read at the current head
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[q_idx] <= link_wdata;
      end
      link_rd_ff <= link_mem[head_ff.idx];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_head_below_hwm: assert property (@(posedge clock) disable iff (reset)
      head_ff.valid |-> (CntW'(head_ff.idx) < hwm_ff))
      else $error("free-list head beyond high-water mark");

   a_push_allocated: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == UOP_PUSH) |-> slot_rd_ff.alloc)
      else $error("pushing a slot that is not allocated");

endmodule

### src/fbpa_sequencer.sv
module fbpa_sequencer import fbpa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  flags_type flags,
   output ctrl_type  ctrl,
   output logic      busy
);

   upc_type   upc_ff, upc_in;
   uword_type word;
   logic      take;

   always_comb begin
      word = ucode_rom(upc_ff);
      unique case (word.cond)
         UC_NEXT:        take = 1'b0;
         UC_ALWAYS:      take = 1'b1;
         UC_NO_START:    take = !start;
         UC_CMD_ALLOC:   take = flags.cmd_alloc;
         UC_CMD_RSVD:    take = flags.cmd_rsvd;
         UC_STRIDE_ZERO: take = flags.stride_zero;
         UC_DIV_BUSY:    take = flags.div_busy;
         UC_ADDR_BAD:    take = flags.addr_bad;
         UC_NOT_ALLOC:   take = flags.not_alloc;
         UC_IS_QUERY:    take = flags.is_query;
         UC_HEAD_NULL:   take = flags.head_null;
         UC_CANNOT_GROW: take = flags.cannot_grow;
         UC_CLR_MORE:    take = flags.clr_more;
         default:        take = 1'b1;
      endcase
      upc_in = take ? word.target : upc_ff + upc_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= U_CLEAR;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign ctrl.op     = word.op;
   assign ctrl.status = word.status;
   assign busy        = upc_ff != U_IDLE;

   a_div_wait_only_from_go: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == U_DIV_WAIT) |-> ($past(upc_ff) == U_DIV_GO || $past(upc_ff) == U_DIV_WAIT))
      else $error("divider wait entered without a start step");

endmodule

### src/fixed_block_pool_allocator_core.sv
// Allocate answers from the free list, else from a fresh slot, else with exhausted. Free and
// query run the bit-serial divider (skipped with a zero stride); a reserved command answers
// with bad address. One command in flight.
// Next beat accepted in the strobe cycle; rsp_valid is a one-cycle strobe, never stalled.
// Synchronous reset; afterwards busy stays high while the slot store's allocated flags are
// swept clear. Configuration is taken at any time.
module fixed_block_pool_allocator_core import fbpa_pkg::*; #(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
   parameter int GUARD_BYTES  = GUARD_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata
);

   ctrl_type  ctrl;
   flags_type flags;

   fbpa_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   fbpa_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .GUARD_BYTES  (GUARD_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .flags     (flags),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while the sequencer is busy");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import fbpa_pkg::*;

   localparam int POOL_DEPTH = MAX_ELEMENTS_DEF;
   localparam int GUARD = GUARD_BYTES_DEF;
   localparam logic [31:0] NO_SLOT = 32'hFFFF_FFFF;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   req_type                req_data = '0;
   logic                   rsp_valid;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]            csr_wdata = '0;

   int errors = 0;
   int idle_pct = 0;
   rsp_type answers_due [$];

   // shadow copy of the pool: registers, free list and slot flags
   logic [31:0] cfg_base = '0;
   logic [31:0] cfg_offset = '0;
   logic [15:0] cfg_size = '0;
   logic [8:0]  cfg_count = '0;
   logic [15:0] cfg_pnum = '0;
   logic [31:0] free_head = NO_SLOT;
   int unsigned hwm = 0;
   logic [31:0] next_link [POOL_DEPTH];
   bit          in_use [POOL_DEPTH];
   logic [15:0] stamp [POOL_DEPTH];

   fixed_block_pool_allocator_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int unsigned count_cap();
      return (cfg_count > POOL_DEPTH) ? POOL_DEPTH : cfg_count;
   endfunction

   function automatic logic [31:0] stride_bytes();
      return ((32'(cfg_size) + 32'd3) & ~32'd3) + GUARD;
   endfunction

   function automatic logic [31:0] slot_address(input int unsigned idx);
      return cfg_base + cfg_offset + 32'(idx) * stride_bytes() + GUARD / 2;
   endfunction

   function automatic bit locate_slot(input logic [31:0] addr, output int unsigned idx);
      logic [31:0] offset;
      logic [31:0] str;
      logic [31:0] q;
      str = stride_bytes();
      offset = addr - GUARD / 2 - (cfg_base + cfg_offset);
      idx = 0;
      if (str == 0) begin
         return 1'b0;
      end
      q = offset / str;
      if (q >= count_cap()) begin
         return 1'b0;
      end
      if (q * str != offset) begin
         return 1'b0;
      end
      idx = q;
      return 1'b1;
   endfunction

   task automatic pool_step(input logic [1:0] cmd, input logic [31:0] addr,
                            output rsp_type ans);
      int unsigned slot;
      ans = '0;
      ans.status = ST_BAD_ADDR;
      case (cmd)
         CMD_ALLOC: begin
            // empty list: take a fresh slot below the count
            if (free_head == NO_SLOT && hwm < count_cap()) begin
               next_link[hwm] = NO_SLOT;
               free_head = hwm;
               hwm++;
            end
            if (free_head != NO_SLOT) begin
               slot = free_head;
               free_head = next_link[slot];
               in_use[slot] = 1'b1;
               stamp[slot] = cfg_pnum;
               ans.result_address = slot_address(slot);
               ans.status = ST_OK;
            end else begin
               ans.status = ST_EXHAUSTED;
            end
         end
         CMD_FREE: begin
            if (!locate_slot(addr, slot)) begin
               ans.status = ST_BAD_ADDR;
            end else if (!in_use[slot]) begin
               ans.status = ST_NOT_ALLOC;
            end else begin
               in_use[slot] = 1'b0;
               next_link[slot] = free_head;
               free_head = slot;
               ans.status = ST_OK;
            end
         end
         CMD_QUERY: begin
            if (!locate_slot(addr, slot)) begin
               ans.status = ST_BAD_ADDR;
            end else if (!in_use[slot]) begin
               ans.status = ST_NOT_ALLOC;
            end else begin
               ans.owner_partition = stamp[slot];
               ans.status = ST_OK;
            end
         end
         default: ;
      endcase
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_pool_config(input logic [31:0] base, input logic [31:0] offset,
                                  input logic [15:0] size, input logic [8:0] count,
                                  input logic [15:0] pnum);
      write_reg(CSR_BASE_ADDRESS, base);
      write_reg(CSR_PARTITION_OFFSET, offset);
      write_reg(CSR_ELEMENT_SIZE, 32'(size));
      write_reg(CSR_ELEMENT_COUNT, 32'(count));
      write_reg(CSR_PARTITION_NUMBER, 32'(pnum));
      csr_we <= 1'b0;
      cfg_base = base;
      cfg_offset = offset;
      cfg_size = size;
      cfg_count = count;
      cfg_pnum = pnum;
   endtask

   // start stays high across back-to-back beats; this task lowers it only for an idle gap
   task automatic send_item(input logic [1:0] cmd, input logic [31:0] addr);
      req_type item;
      rsp_type ans;
      item.command = cmd;
      item.element_address = addr;
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      pool_step(cmd, addr, ans);
      answers_due.push_back(ans);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(45, 1)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      int n;
      n = 0;
      while (answers_due.size() != 0 && n < 5000) begin
         @(posedge clock);
         n++;
      end
      if (answers_due.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, answers_due.size());
         errors++;
         answers_due.delete();
      end
   endtask

   task automatic run_random(input int n, input int alloc_pct);
      int r;
      int unsigned idx;
      logic [31:0] addr;
      logic [1:0] probe;
      for (int k = 0; k < n; k++) begin
         idx = $urandom_range(hwm + 1);
         addr = slot_address(idx);
         probe = $urandom_range(1) ? CMD_FREE : CMD_QUERY;
         r = $urandom_range(99);
         if (r < alloc_pct) begin
            send_item(CMD_ALLOC, $urandom);
         end else begin
            r = $urandom_range(99);
            if (r < 45) begin
               send_item(CMD_FREE, addr);
            end else if (r < 75) begin
               send_item(CMD_QUERY, addr);
            end else if (r < 85) begin
               send_item(probe, addr ^ (32'd1 << $urandom_range(31)));
            end else if (r < 93) begin
               send_item(probe, $urandom);
            end else begin
               send_item(CMD_RSVD, $urandom);
            end
         end
      end
      start <= 1'b0;
      wait_drained();
   endtask

   task automatic test_basic_commands();
      idle_pct = 0;
      set_pool_config(32'h0000_1000, 32'h0000_0020, 16'd5, 9'd4, 16'hABCD);
      send_item(CMD_QUERY, slot_address(0));
      repeat (4) send_item(CMD_ALLOC, 32'h0);
      send_item(CMD_ALLOC, 32'hFFFF_FFFF);      // pool used up
      send_item(CMD_QUERY, slot_address(2));
      send_item(CMD_FREE, slot_address(1));
      send_item(CMD_FREE, slot_address(1));     // double free
      send_item(CMD_FREE, slot_address(2) + 2); // misaligned
      send_item(CMD_FREE, slot_address(4));     // past the count
      send_item(CMD_RSVD, 32'hFFFF_FFFF);
      send_item(CMD_ALLOC, 32'h0);
      send_item(CMD_FREE, slot_address(0));
      send_item(CMD_FREE, slot_address(3));
      send_item(CMD_ALLOC, 32'h0);
      send_item(CMD_ALLOC, 32'h0);
      send_item(CMD_QUERY, 32'h0);
      send_item(CMD_QUERY, 32'hFFFF_FFFF);
      start <= 1'b0;
      wait_drained();
   endtask

   task automatic test_shrunk_count();
      idle_pct = 0;
      set_pool_config(32'h0000_1000, 32'h0000_0020, 16'd5, 9'd2, 16'h0001);
      send_item(CMD_FREE, slot_address(3));     // above the lowered count
      send_item(CMD_FREE, slot_address(1));
      send_item(CMD_ALLOC, 32'h0);
      send_item(CMD_ALLOC, 32'h0);
      send_item(CMD_QUERY, slot_address(1));
      start <= 1'b0;
      wait_drained();
   endtask

   task automatic test_steady_pool();
      idle_pct = 0;
      set_pool_config(32'h4000_0000, 32'h0000_0100, 16'd12, 9'd16, 16'h1234);
      run_random(200, 40);
   endtask

   task automatic test_idle_sender();
      idle_pct = 50;
      set_pool_config($urandom, $urandom, 16'($urandom_range(64)), 9'd8, 16'($urandom));
      run_random(180, 40);
   endtask

   task automatic test_wrapping_heap();
      idle_pct = 29;
      set_pool_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 9'd256, 16'hFFFF);
      run_random(180, 45);
   endtask

   task automatic test_empty_partition();
      idle_pct = 50;
      set_pool_config(32'h0, 32'h0, 16'd0, 9'd0, 16'h0);
      run_random(100, 40);
   endtask

   task automatic test_count_overflow();
      idle_pct = 0;
      set_pool_config($urandom, $urandom, 16'd3, 9'd511, 16'($urandom));
      run_random(250, 70);
   endtask

   task automatic test_small_partition();
      idle_pct = 29;
      set_pool_config($urandom, $urandom, 16'($urandom_range(200)), 9'd5, 16'($urandom));
      run_random(150, 40);
   endtask

   task automatic test_random_config();
      int gaps [3];
      gaps[0] = 29;
      gaps[1] = 50;
      gaps[2] = 0;
      for (int p = 0; p < 3; p++) begin
         idle_pct = gaps[p];
         set_pool_config($urandom, $urandom, 16'($urandom_range(65535)),
                         9'($urandom_range(511)), 16'($urandom));
         run_random(100, 40);
      end
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (answers_due.size() == 0) begin
            $display("%0t: unexpected response, expected none actual %h", $time, rsp_data);
            errors++;
         end else begin
            want = answers_due.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.result_address !== want.result_address) begin
               $display("%0t: result_address expected %h actual %h",
                        $time, want.result_address, rsp_data.result_address);
               errors++;
            end
            if (rsp_data.owner_partition !== want.owner_partition) begin
               $display("%0t: owner_partition expected %h actual %h",
                        $time, want.owner_partition, rsp_data.owner_partition);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_basic_commands();
      test_shrunk_count();
      test_steady_pool();
      test_idle_sender();
      test_wrapping_heap();
      test_empty_partition();
      test_count_overflow();
      test_small_partition();
      test_random_config();
      wait_drained();
      // catch any stray beats after the last answer
      repeat (60) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("%0t: run timed out", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
